// ===== rtl/core/kbrd_pkg.sv =====
// Shared types and constants for the sorted-table block record deframer.
// No dependencies; used by kbrd_parser and kv_block_record_deframer.
`default_nettype none

package kbrd_pkg;

    // Default cap on a block's length in bytes.
    localparam longint unsigned DEF_MAX_BLOCK_BYTES = 64'd65535;

    // Smallest record: flag byte, two 4-byte lengths, empty key and value.
    localparam int unsigned REC_MIN_BYTES = 9;
    // Bytes in each little-endian length field.
    localparam int unsigned LEN_BYTES = 4;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_KLEN  = 3'd1,
        PH_KEY   = 3'd2,
        PH_VLEN  = 3'd3,
        PH_VALUE = 3'd4,
        PH_STOP  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_HDR     = 2'd0,
        ROLE_KEY     = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_IGNORED = 2'd3
    } t_role;

    typedef struct packed {
        logic [15:0] block_length;
        logic        block_begin;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic        entry_dropped;
        logic        entry_done;
        logic        key_done;
        logic        tombstone;
        t_role       role;
        logic [7:0]  out_byte;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/kbrd_parser.sv =====
// Record parser state machine: tags one block byte per request.
// Depends on kbrd_pkg for the phase, role, item and result types.
`default_nettype none

module kbrd_parser
    import kbrd_pkg::*;
#(
    parameter longint unsigned MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire t_item   i_item,
    output t_result      o_result
);

    // Offsets and counts never exceed the (clamped) block size.
    localparam int SIZE_W = (MAX_BLOCK_BYTES >= 64'd65535) ? 16
                                                           : $clog2(MAX_BLOCK_BYTES + 64'd1);
    localparam logic [15:0] LEN_CAP = (MAX_BLOCK_BYTES >= 64'd65535) ? 16'hFFFF
                                                                     : 16'(MAX_BLOCK_BYTES);

    t_phase              r_phase, n_phase;
    logic [SIZE_W-1:0]   r_offset, n_offset;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [31:0]         r_gather, n_gather;
    logic [SIZE_W-1:0]   r_left, n_left;
    logic                r_tomb, n_tomb;

    // State as seen by this byte: a block start restarts everything.
    t_phase              w_phase;
    logic [SIZE_W-1:0]   w_pos;
    logic [SIZE_W-1:0]   w_size;
    logic [31:0]         w_gather;
    logic [SIZE_W-1:0]   w_left;
    logic                w_tomb;
    logic [15:0]         w_len_clamped;

    logic [31:0]         w_gather_nx;
    logic [SIZE_W-1:0]   w_left_m1;
    logic                w_len_last;
    logic [33:0]         w_need;
    logic                w_start_bad;
    logic                w_key_bad;
    logic                w_val_bad;

    always_comb begin
        w_len_clamped = (i_item.block_length > LEN_CAP) ? LEN_CAP : i_item.block_length;
        if (i_item.block_begin) begin
            w_phase  = PH_START;
            w_pos    = '0;
            w_size   = SIZE_W'(w_len_clamped);
            w_gather = '0;
            w_left   = '0;
            w_tomb   = 1'b0;
        end else begin
            w_phase  = r_phase;
            w_pos    = r_offset;
            w_size   = r_size;
            w_gather = r_gather;
            w_left   = r_left;
            w_tomb   = r_tomb;
        end
    end

    // Length bytes arrive low byte first and shift in from the top.
    assign w_gather_nx = {i_item.data_byte, w_gather[31:8]};
    assign w_left_m1   = w_left - SIZE_W'(1);
    assign w_len_last  = (w_left_m1 == '0);
    assign w_need      = 34'(w_pos) + 34'(w_gather_nx) + 34'd1;
    assign w_start_bad = (34'(w_pos) + 34'(REC_MIN_BYTES)) > 34'(w_size);
    assign w_key_bad   = (w_need + 34'(LEN_BYTES)) > 34'(w_size);
    assign w_val_bad   = w_need > 34'(w_size);

    // Next state.
    always_comb begin
        n_phase  = w_phase;
        n_size   = w_size;
        n_gather = w_gather;
        n_left   = w_left;
        n_tomb   = w_tomb;
        unique case (w_phase)
            PH_START: begin
                if (w_start_bad) begin
                    n_phase = PH_STOP;
                end else begin
                    n_tomb   = |i_item.data_byte;
                    n_phase  = PH_KLEN;
                    n_left   = SIZE_W'(LEN_BYTES);
                    n_gather = '0;
                end
            end
            PH_KLEN, PH_VLEN: begin
                n_gather = w_gather_nx;
                n_left   = w_left_m1;
                if (w_len_last) begin
                    if ((w_phase == PH_KLEN) ? w_key_bad : w_val_bad) begin
                        n_phase = PH_STOP;
                    end else if (w_gather_nx == '0) begin
                        n_phase = (w_phase == PH_KLEN) ? PH_VLEN : PH_START;
                        n_left  = (w_phase == PH_KLEN) ? SIZE_W'(LEN_BYTES) : w_left_m1;
                    end else begin
                        n_phase = (w_phase == PH_KLEN) ? PH_KEY : PH_VALUE;
                        // The bounds check keeps the length below the block size.
                        n_left  = SIZE_W'(w_gather_nx);
                    end
                end
            end
            PH_KEY: begin
                n_left = w_left_m1;
                if (w_len_last) begin
                    n_phase  = PH_VLEN;
                    n_left   = SIZE_W'(LEN_BYTES);
                    n_gather = '0;
                end
            end
            PH_VALUE: begin
                n_left = w_left_m1;
                if (w_len_last) begin
                    n_phase = PH_START;
                end
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase
    end

    // Outputs for this byte.
    always_comb begin
        o_result               = '0;
        o_result.out_byte      = i_item.data_byte;
        o_result.role          = ROLE_IGNORED;
        unique case (w_phase)
            PH_START: begin
                if (!w_start_bad) begin
                    o_result.role = ROLE_HDR;
                end
            end
            PH_KLEN: begin
                o_result.role = ROLE_HDR;
                if (w_len_last) begin
                    o_result.entry_dropped = w_key_bad;
                    o_result.key_done      = !w_key_bad && (w_gather_nx == '0);
                end
            end
            PH_VLEN: begin
                o_result.role = ROLE_HDR;
                if (w_len_last) begin
                    o_result.entry_dropped = w_val_bad;
                    o_result.entry_done    = !w_val_bad && (w_gather_nx == '0);
                end
            end
            PH_KEY: begin
                o_result.role     = ROLE_KEY;
                o_result.key_done = w_len_last;
            end
            PH_VALUE: begin
                o_result.role       = ROLE_VALUE;
                o_result.entry_done = w_len_last;
            end
            default: begin
                o_result.role = ROLE_IGNORED;
            end
        endcase
        o_result.tombstone = (o_result.role != ROLE_IGNORED) && n_tomb;
        n_offset = (o_result.role != ROLE_IGNORED) ? (w_pos + SIZE_W'(1)) : w_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_offset <= '0;
            r_size   <= '0;
            r_gather <= '0;
            r_left   <= '0;
            r_tomb   <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_size   <= n_size;
            r_gather <= n_gather;
            r_left   <= n_left;
            r_tomb   <= n_tomb;
        end
    end

`ifndef NO_ASSERTIONS
    a_offset_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= r_size)
        else $error("parser offset ran past the block size");

    a_drop_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_result.entry_dropped) |=> (r_phase == PH_STOP))
        else $error("dropped entry did not stop parsing");

    a_stop_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STOP && !(i_accept && i_item.block_begin)) |=> (r_phase == PH_STOP))
        else $error("parser left stop without a block start");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_KEY || r_phase == PH_VALUE || r_phase == PH_KLEN
         || r_phase == PH_VLEN) |-> (r_left != '0))
        else $error("byte counter empty inside a record part");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/kv_block_record_deframer.sv =====
// Top level of the sorted-table data block record deframer.
// Depends on kbrd_pkg and kbrd_parser; holds the result register.
//
//   Channel   Dir  tdata                                  tuser / tlast
//   s_axis    in   [7:0] data_byte, [23:8] block_length   tuser: block_begin
//   m_axis    out  [7:0] out_byte                         tuser: role, tombstone,
//                                                         key_done, entry_dropped;
//                                                         tlast: entry_done
//
// Every byte request is parsed in the cycle it is accepted and its result appears
// on m_axis in the next cycle; one byte per clock is sustained, set by the single
// counter update and length compare in the parser. Reset (synchronous, active low)
// returns the parser to a record start with a zero block size, so bytes are ignored
// until a block start arrives, and empties the result register. When m_axis stalls
// the result register holds and s_axis_tready drops until the result is taken.
`default_nettype none

module kv_block_record_deframer
    import kbrd_pkg::*;
#(
    parameter longint unsigned MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] block_length
    input  wire logic        s_axis_tuser,   // [0] block_begin
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]       m_axis_tuser,   // [1:0] role, [2] tombstone, [3] key_done,
                                             // [4] entry_dropped
    output logic             m_axis_tlast    // entry_done
);

    logic    w_accept;
    t_item   w_item;
    t_result w_result;

    logic    r_out_valid;
    t_result r_out;

    // A new byte is taken whenever the result register is free or being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_item.data_byte    = s_axis_tdata[7:0];
    assign w_item.block_length = s_axis_tdata[23:8];
    assign w_item.block_begin  = s_axis_tuser;

    kbrd_parser #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (w_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.out_byte;
    assign m_axis_tuser  = {r_out.entry_dropped, r_out.key_done, r_out.tombstone, r_out.role};
    assign m_axis_tlast  = r_out.entry_done;

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> m_axis_tvalid)
        else $error("accepted byte produced no result");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.role == ROLE_IGNORED)
        |-> !(r_out.tombstone || r_out.key_done || r_out.entry_done || r_out.entry_dropped))
        else $error("ignored byte carries a marker");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0({r_out.key_done, r_out.entry_done, r_out.entry_dropped}))
        else $error("more than one record event on one byte");
`endif

endmodule

`default_nettype wire
